### rtl/core/lsbx_pkg.sv
// ----------------------------------------------------------------------------
// lsbx_pkg
// Shared types and constants for the LSB payload extractor: register indexes,
// reset values, result kinds, error codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbx_pkg;

    // default and upper limit of the magic string length
    localparam int MAGIC_CHARS_MAX_DEFAULT = 8;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_CHARS  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_EXT_LEN  = 2'd3;

    // register reset values
    localparam logic [7:0] HEADER_SKIP_RESET  = 8'd54;
    localparam logic [3:0] MAGIC_LENGTH_RESET = 4'd2;
    localparam logic [7:0] MAX_EXT_LEN_RESET  = 8'd4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_EXT     = 2'd0,
        KIND_SIZE    = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    // error codes carried in the value field
    localparam logic [31:0] ERR_MAGIC  = 32'd1;
    localparam logic [31:0] ERR_EXTLEN = 32'd2;

    // one result from the parser
    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        kind_t       kind;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

### rtl/core/lsbx_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsbx_cfg_regs
// Configuration register file: header skip, magic length, magic characters
// and extension length limit, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_cfg_regs #(
    parameter int MAGIC_MAX_CHARS = lsbx_pkg::MAGIC_CHARS_MAX_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lsbx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lsbx_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [7:0]                               header_skip,
    output logic [3:0]                               magic_length,
    output logic [MAGIC_MAX_CHARS-1:0][7:0]          magic_chars,
    output logic [7:0]                               max_ext_len
);
    import lsbx_pkg::*;

    logic [7:0]                      header_skip_reg;
    logic [3:0]                      magic_length_reg;
    logic [MAGIC_MAX_CHARS-1:0][7:0] magic_chars_reg;
    logic [7:0]                      max_ext_len_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg  <= HEADER_SKIP_RESET;
            magic_length_reg <= MAGIC_LENGTH_RESET;
            magic_chars_reg  <= '0;
            max_ext_len_reg  <= MAX_EXT_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_SKIP:  header_skip_reg  <= cfg_data[7:0];
                REG_MAGIC_LENGTH: magic_length_reg <= cfg_data[3:0];
                REG_MAGIC_CHARS:  magic_chars_reg  <= cfg_data[8*MAGIC_MAX_CHARS-1:0];
                REG_MAX_EXT_LEN:  max_ext_len_reg  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign header_skip  = header_skip_reg;
    assign magic_length = magic_length_reg;
    assign magic_chars  = magic_chars_reg;
    assign max_ext_len  = max_ext_len_reg;

endmodule

`default_nettype wire

### rtl/core/lsbx_parser.sv
// ----------------------------------------------------------------------------
// lsbx_parser
// Parse state and single-pass next-state logic: header skip, bit gathering,
// magic check, extension length, extension chars, size and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbx_parser #(
    parameter int MAGIC_MAX_CHARS = lsbx_pkg::MAGIC_CHARS_MAX_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic [7:0]                          pixel_byte,
    input  wire logic                                start_req,
    input  wire logic [7:0]                          header_skip,
    input  wire logic [3:0]                          magic_length,
    input  wire logic [MAGIC_MAX_CHARS-1:0][7:0]     magic_chars,
    input  wire logic [7:0]                          max_ext_len,
    output lsbx_pkg::res_t                           res
);
    import lsbx_pkg::*;

    localparam int MPW = (MAGIC_MAX_CHARS > 1) ? $clog2(MAGIC_MAX_CHARS) : 1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXT     = 3'd3,
        PH_SIZE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_STOP    = 3'd6
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [7:0]  skip_reg,      skip_next;
    logic [2:0]  bitc_reg,      bitc_next;
    logic [7:0]  shift_reg,     shift_next;
    logic [31:0] word_reg,      word_next;
    logic [1:0]  bidx_reg,      bidx_next;
    logic [31:0] rem_reg,       rem_next;
    logic [3:0]  mpos_reg,      mpos_next;

    logic [3:0]  mlen;
    logic [7:0]  hb;
    logic [31:0] wsum;
    logic [7:0]  want;
    logic        skipped;

    // magic length saturated to the supported maximum
    assign mlen = (magic_length > 4'(MAGIC_MAX_CHARS)) ? 4'(MAGIC_MAX_CHARS) : magic_length;

    // next state and result for one image byte
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        bitc_next  = bitc_reg;
        shift_next = shift_reg;
        word_next  = word_reg;
        bidx_next  = bidx_reg;
        rem_next   = rem_reg;
        mpos_next  = mpos_reg;
        res        = '0;
        res.kind   = KIND_EXT;
        hb         = '0;
        wsum       = '0;
        want       = '0;
        skipped    = 1'b0;

        if (en)
        begin
            // start of a new image clears parse state
            if (start_req)
            begin
                phase_next = PH_HEADER;
                skip_next  = '0;
                bitc_next  = '0;
                shift_next = '0;
                word_next  = '0;
                bidx_next  = '0;
                rem_next   = '0;
                mpos_next  = '0;
            end

            // header skip
            if (phase_next == PH_HEADER)
            begin
                if (skip_next < header_skip)
                begin
                    skip_next = skip_next + 8'd1;
                    skipped   = 1'b1;
                end
                else
                begin
                    phase_next = PH_MAGIC;
                    mpos_next  = '0;
                    bitc_next  = '0;
                    shift_next = '0;
                end
            end

            if (!skipped && phase_next <= PH_PAYLOAD)
            begin
                // gather the lsb, msb first
                hb = {shift_next[6:0], pixel_byte[0]};
                if (bitc_next != 3'd7)
                begin
                    shift_next = hb;
                    bitc_next  = bitc_next + 3'd1;
                end
                else
                begin
                    bitc_next  = '0;
                    shift_next = '0;

                    // magic done: move to the extension length
                    if (phase_next == PH_MAGIC && mpos_next >= mlen)
                    begin
                        phase_next = PH_EXTLEN;
                        word_next  = '0;
                        bidx_next  = '0;
                    end

                    wsum = word_next | (32'(hb) << {bidx_next, 3'b000});
                    want = magic_chars[mpos_next[MPW-1:0]];

                    unique case (phase_next)
                        PH_MAGIC:
                        begin
                            if (hb != want)
                            begin
                                phase_next = PH_STOP;
                                res.valid  = 1'b1;
                                res.value  = ERR_MAGIC;
                                res.kind   = KIND_ERROR;
                                res.last   = 1'b1;
                            end
                            else
                            begin
                                mpos_next = mpos_next + 4'd1;
                            end
                        end
                        PH_EXTLEN:
                        begin
                            word_next = wsum;
                            if (bidx_next == 2'd3)
                            begin
                                bidx_next = '0;
                                if (wsum > 32'(max_ext_len))
                                begin
                                    phase_next = PH_STOP;
                                    res.valid  = 1'b1;
                                    res.value  = ERR_EXTLEN;
                                    res.kind   = KIND_ERROR;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    rem_next   = wsum;
                                    word_next  = '0;
                                    phase_next = (wsum == '0) ? PH_SIZE : PH_EXT;
                                end
                            end
                            else
                            begin
                                bidx_next = bidx_next + 2'd1;
                            end
                        end
                        PH_EXT:
                        begin
                            rem_next = rem_next - 32'd1;
                            if (rem_next == '0)
                            begin
                                phase_next = PH_SIZE;
                                word_next  = '0;
                                bidx_next  = '0;
                            end
                            res.valid = 1'b1;
                            res.value = 32'(hb);
                            res.kind  = KIND_EXT;
                        end
                        PH_SIZE:
                        begin
                            word_next = wsum;
                            if (bidx_next == 2'd3)
                            begin
                                bidx_next = '0;
                                word_next = '0;
                                res.valid = 1'b1;
                                res.value = wsum;
                                res.kind  = KIND_SIZE;
                                // empty or oversized file ends the image here
                                if (wsum == '0 || wsum[31])
                                begin
                                    phase_next = PH_STOP;
                                    res.last   = 1'b1;
                                end
                                else
                                begin
                                    rem_next   = wsum;
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                            else
                            begin
                                bidx_next = bidx_next + 2'd1;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            rem_next  = rem_next - 32'd1;
                            res.valid = 1'b1;
                            res.value = 32'(hb);
                            res.kind  = KIND_PAYLOAD;
                            if (rem_next == '0)
                            begin
                                phase_next = PH_STOP;
                                res.last   = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            skip_reg  <= '0;
            bitc_reg  <= '0;
            shift_reg <= '0;
            word_reg  <= '0;
            bidx_reg  <= '0;
            rem_reg   <= '0;
            mpos_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            bitc_reg  <= bitc_next;
            shift_reg <= shift_next;
            word_reg  <= word_next;
            bidx_reg  <= bidx_next;
            rem_reg   <= rem_next;
            mpos_reg  <= mpos_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lsb_stego_payload_extractor.sv
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor
// An accepted image byte is held in the input register, then parsed into the
// result register by the single-pass parser between the two registers. The
// parser takes one image byte per cycle while the result register is free or
// m_tready is high; a stalled result register holds the byte and drops s_tready.
// Reset: asynchronous; clears parse state and restores register defaults
// (header skip 54, magic length 2, magic chars 0, extension limit 4).
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_stego_payload_extractor #(
    parameter int MAGIC_MAX_CHARS = lsbx_pkg::MAGIC_CHARS_MAX_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // image byte stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] pixel_byte
    input  wire logic                                s_tuser,   // [0] start_req
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [31:0]                              m_tdata,   // [31:0] value
    output logic [1:0]                               m_tuser,   // [1:0] kind
    output logic                                     m_tlast,
    // configuration write port
    input  wire logic                                cfg_we,
    input  wire logic [lsbx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [lsbx_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lsbx_pkg::*;

    logic [7:0]                      header_skip;
    logic [3:0]                      magic_length;
    logic [MAGIC_MAX_CHARS-1:0][7:0] magic_chars;
    logic [7:0]                      max_ext_len;

    logic        in_valid_reg;
    logic [7:0]  pix_reg;
    logic        start_reg;
    logic        proc_en;
    res_t        res;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    kind_t       out_kind_reg;
    logic        out_last_reg;

    // configuration registers
    lsbx_cfg_regs #(
        .MAGIC_MAX_CHARS (MAGIC_MAX_CHARS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .header_skip  (header_skip),
        .magic_length (magic_length),
        .magic_chars  (magic_chars),
        .max_ext_len  (max_ext_len)
    );

    // the held byte is parsed when the result register can take its result
    assign proc_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_en;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pix_reg   <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    // parser
    lsbx_parser #(
        .MAGIC_MAX_CHARS (MAGIC_MAX_CHARS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (proc_en),
        .pixel_byte   (pix_reg),
        .start_req    (start_reg),
        .header_skip  (header_skip),
        .magic_length (magic_length),
        .magic_chars  (magic_chars),
        .max_ext_len  (max_ext_len),
        .res          (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_en)
        begin
            out_valid_reg <= res.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en && res.valid)
        begin
            out_value_reg <= res.value;
            out_kind_reg  <= res.kind;
            out_last_reg  <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### bench/lsb_stego_payload_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor_test
// Self-checking bench for the LSB payload extractor. Images are built as byte
// streams that hide magic, extension length, extension chars, file size and
// payload in their low bits. A parser model in the bench tracks every
// accepted byte and queues the results it should produce. A monitor compares
// each output transaction with the oldest queued result. Both stream sides
// idle in random bursts. Configuration changes only while the block is idle.
// ----------------------------------------------------------------------------

module lsb_stego_payload_extractor_test;

    import lsbx_pkg::*;

    localparam int MAGIC_MAX      = MAGIC_CHARS_MAX_DEFAULT;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int FULL_IMAGE     = 1 << 30;
    localparam int RANDOM_PHASES  = 3;
    localparam int PHASE_ITEMS    = 40;

    // parser phases tracked by the model
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_MAGIC   = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_EXT     = 3'd3,
        PH_SIZE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_STOP    = 3'd6
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] pix;
        logic       start;
    } pixel_t;

    typedef struct packed {
        logic [31:0] value;
        kind_t       kind;
        logic        last;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'd0;   // [7:0] pixel_byte
    logic                   s_tuser   = 1'b0;   // [0] start_req
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [31:0]            m_tdata;            // [31:0] value
    logic [1:0]             m_tuser;            // [1:0] kind
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies
    logic [7:0]  skip_cfg      = HEADER_SKIP_RESET;
    logic [3:0]  magic_len_cfg = MAGIC_LENGTH_RESET;
    logic [63:0] magic_cfg     = 64'd0;
    logic [7:0]  ext_limit_cfg = MAX_EXT_LEN_RESET;

    // parser state copy
    parse_phase_t phase_st   = PH_HEADER;
    logic [7:0]   skip_cnt   = 8'd0;
    logic [2:0]   bit_cnt    = 3'd0;
    logic [7:0]   bit_shift  = 8'd0;
    logic [31:0]  le_word    = 32'd0;
    logic [1:0]   le_idx     = 2'd0;
    logic [31:0]  count_left = 32'd0;
    logic [3:0]   magic_pos  = 4'd0;

    pixel_t   pending_pixels[$];
    outcome_t due_results[$];
    pixel_t   next_pixel;
    outcome_t owed;

    int  items_queued = 0;
    int  items_taken  = 0;
    int  mismatches   = 0;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    int  src_rate     = 0;
    int  sink_rate    = 0;
    int  idle_cycles  = 0;
    int  room         = FULL_IMAGE;
    bit  start_flag   = 1'b0;

    lsb_stego_payload_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    task automatic owe_result(input logic [31:0] value, input kind_t kind, input logic last);
        outcome_t r;
        r.value = value;
        r.kind  = kind;
        r.last  = last;
        due_results.insert(due_results.size(), r);
    endtask

    // little-endian word gather, true once four bytes are in
    function automatic bit gather_le_byte(input logic [7:0] h);
        le_word = le_word | ({24'd0, h} << (8 * le_idx));
        if (le_idx == 2'd3)
        begin
            le_idx = 2'd0;
            return 1'b1;
        end
        le_idx++;
        return 1'b0;
    endfunction

    task automatic parse_hidden_byte(input logic [7:0] h);
        logic [3:0]  mlen;
        logic [31:0] size_val;
        mlen = (magic_len_cfg > 4'(MAGIC_MAX)) ? 4'(MAGIC_MAX) : magic_len_cfg;
        // magic done (or empty), move on to the extension length
        if (phase_st == PH_MAGIC && magic_pos >= mlen)
        begin
            phase_st = PH_EXTLEN;
            le_word  = 32'd0;
            le_idx   = 2'd0;
        end
        case (phase_st)
            PH_MAGIC:
            begin
                if (h != magic_cfg[8 * magic_pos[2:0] +: 8])
                begin
                    phase_st = PH_STOP;
                    owe_result(ERR_MAGIC, KIND_ERROR, 1'b1);
                end
                else
                    magic_pos++;
            end
            PH_EXTLEN:
            begin
                if (gather_le_byte(h))
                begin
                    if (le_word > {24'd0, ext_limit_cfg})
                    begin
                        phase_st = PH_STOP;
                        owe_result(ERR_EXTLEN, KIND_ERROR, 1'b1);
                    end
                    else
                    begin
                        count_left = le_word;
                        le_word    = 32'd0;
                        phase_st   = (count_left == 32'd0) ? PH_SIZE : PH_EXT;
                    end
                end
            end
            PH_EXT:
            begin
                count_left--;
                if (count_left == 32'd0)
                begin
                    phase_st = PH_SIZE;
                    le_word  = 32'd0;
                    le_idx   = 2'd0;
                end
                owe_result({24'd0, h}, KIND_EXT, 1'b0);
            end
            PH_SIZE:
            begin
                if (gather_le_byte(h))
                begin
                    size_val = le_word;
                    le_word  = 32'd0;
                    // empty or huge size ends the image here
                    if (size_val == 32'd0 || size_val[31])
                    begin
                        phase_st = PH_STOP;
                        owe_result(size_val, KIND_SIZE, 1'b1);
                    end
                    else
                    begin
                        count_left = size_val;
                        phase_st   = PH_PAYLOAD;
                        owe_result(size_val, KIND_SIZE, 1'b0);
                    end
                end
            end
            PH_PAYLOAD:
            begin
                count_left--;
                if (count_left == 32'd0)
                begin
                    phase_st = PH_STOP;
                    owe_result({24'd0, h}, KIND_PAYLOAD, 1'b1);
                end
                else
                    owe_result({24'd0, h}, KIND_PAYLOAD, 1'b0);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic parse_pixel(input logic [7:0] pix, input logic start);
        logic [7:0] h;
        if (start)
        begin
            phase_st   = PH_HEADER;
            skip_cnt   = 8'd0;
            bit_cnt    = 3'd0;
            bit_shift  = 8'd0;
            le_word    = 32'd0;
            le_idx     = 2'd0;
            count_left = 32'd0;
            magic_pos  = 4'd0;
        end
        // header skip uses the current register value
        if (phase_st == PH_HEADER)
        begin
            if (skip_cnt < skip_cfg)
            begin
                skip_cnt++;
                return;
            end
            phase_st  = PH_MAGIC;
            magic_pos = 4'd0;
            bit_cnt   = 3'd0;
            bit_shift = 8'd0;
        end
        if (phase_st == PH_STOP)
            return;
        bit_shift = {bit_shift[6:0], pix[0]};
        if (bit_cnt != 3'd7)
        begin
            bit_cnt++;
            return;
        end
        bit_cnt   = 3'd0;
        h         = bit_shift;
        bit_shift = 8'd0;
        parse_hidden_byte(h);
    endtask

    // ------------------------------------------------------------------
    // image stream builders
    // ------------------------------------------------------------------

    task automatic push_pixel(input logic [7:0] pix);
        pixel_t p;
        if (room == 0)
            return;
        room--;
        p.pix   = pix;
        p.start = start_flag;
        start_flag = 1'b0;
        pending_pixels.insert(pending_pixels.size(), p);
        items_queued++;
    endtask

    // one hidden byte, msb first, in the low bits of eight image bytes
    task automatic push_hidden(input logic [7:0] h);
        logic [7:0] pix;
        for (int i = 7; i >= 0; i--)
        begin
            pix    = 8'($urandom);
            pix[0] = h[i];
            push_pixel(pix);
        end
    endtask

    task automatic push_le_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_hidden(w[8 * i +: 8]);
    endtask

    task automatic push_noise(input int n);
        room = FULL_IMAGE;
        repeat (n) push_pixel(8'($urandom));
    endtask

    task automatic push_image(input bit with_start, input int hdr_len, input bit bad_magic,
                              input logic [31:0] ext_len, input logic [31:0] size,
                              input int room_left);
        int         mlen;
        int         bad_at;
        logic [7:0] c;
        room       = room_left;
        start_flag = with_start;
        mlen       = (magic_len_cfg > 4'(MAGIC_MAX)) ? MAGIC_MAX : int'(magic_len_cfg);
        bad_at     = (bad_magic && mlen > 0) ? $urandom_range(0, mlen - 1) : -1;
        repeat (hdr_len) push_pixel(8'($urandom));
        for (int i = 0; i < mlen; i++)
        begin
            c = magic_cfg[8 * i +: 8];
            if (i == bad_at)
                c = c ^ (8'h1 << $urandom_range(0, 7));
            push_hidden(c);
        end
        push_le_word(ext_len);
        if (ext_len <= {24'd0, ext_limit_cfg})
        begin
            repeat (ext_len) push_hidden(8'($urandom));
            push_le_word(size);
            if (size != 32'd0 && !size[31])
                repeat (size) push_hidden(8'($urandom));
        end
    endtask

    // mostly well-formed images, some broken or cut short
    task automatic push_random_image();
        int          pick;
        int          room_left;
        bit          bad;
        logic [31:0] ext_len;
        logic [31:0] size;
        pick      = $urandom_range(0, 99);
        ext_len   = $urandom_range(0, (ext_limit_cfg < 3) ? ext_limit_cfg : 3);
        size      = $urandom_range(1, 6);
        bad       = 1'b0;
        room_left = FULL_IMAGE;
        if (pick < 8)
            bad = 1'b1;
        else if (pick < 14)
            ext_len = {24'd0, ext_limit_cfg} + $urandom_range(1, 3);
        else if (pick < 16)
            ext_len = $urandom | 32'h100;
        else if (pick < 20)
            size = 32'd0;
        else if (pick < 24)
            size = $urandom | 32'h8000_0000;
        else if (pick < 36)
            room_left = $urandom_range(1, skip_cfg + 8 * 20);
        push_image(1'b1, skip_cfg, bad, ext_len, size, room_left);
        if ($urandom_range(0, 4) == 0)
            push_noise($urandom_range(1, 16));
    endtask

    // ------------------------------------------------------------------
    // configuration and sequencing helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_HEADER_SKIP:  skip_cfg      = data[7:0];
            REG_MAGIC_LENGTH: magic_len_cfg = data[3:0];
            REG_MAGIC_CHARS:  magic_cfg     = data;
            REG_MAX_EXT_LEN:  ext_limit_cfg = data[7:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_config(input logic [7:0] skip, input logic [3:0] mlen,
                              input logic [63:0] magic, input logic [7:0] ext_limit);
        write_reg(REG_HEADER_SKIP, {56'd0, skip});
        write_reg(REG_MAGIC_LENGTH, {60'd0, mlen});
        write_reg(REG_MAGIC_CHARS, magic);
        write_reg(REG_MAX_EXT_LEN, {56'd0, ext_limit});
    endtask

    // wait until every byte is taken and every result is in, then let it settle
    task automatic drain();
        while (items_taken != items_queued || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver: image byte transactions from the pending queue
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                parse_pixel(s_tdata, s_tuser);
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_pixel = pending_pixels.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_pixel.pix;
                    s_tuser   <= next_pixel.start;
                    if (src_rate != 0 && $urandom_range(1, 100) <= src_rate)
                        src_gap = $urandom_range(1, 9);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: check result transactions, random back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                    report_mismatch("unexpected result value", m_tdata, 32'd0);
                else
                begin
                    owed = due_results.pop_front();
                    if (m_tdata !== owed.value)
                        report_mismatch("value", m_tdata, owed.value);
                    if (m_tuser !== owed.kind)
                        report_mismatch("kind", {30'd0, m_tuser}, {30'd0, owed.kind});
                    if (m_tlast !== owed.last)
                        report_mismatch("last", {31'd0, m_tlast}, {31'd0, owed.last});
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_rate != 0 && $urandom_range(1, 100) <= sink_rate)
                    sink_gap = $urandom_range(1, 9);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        src_rate  = 25;
        sink_rate = 25;

        // register defaults: two-char zero magic, extension at the limit of four
        push_image(1'b1, skip_cfg, 1'b0, 32'd4, 32'd3, FULL_IMAGE);
        drain();

        // no header, empty magic, zero extension limit
        set_config(8'd0, 4'd0, 64'd0, 8'd0);
        push_image(1'b1, 0, 1'b0, 32'd0, 32'd2, FULL_IMAGE);
        push_noise(12);
        push_image(1'b1, 0, 1'b0, 32'd1, 32'd2, FULL_IMAGE);
        push_image(1'b1, 0, 1'b0, 32'd0, 32'd0, FULL_IMAGE);
        push_image(1'b1, 0, 1'b0, 32'd0, 32'hFFFF_FFFF, FULL_IMAGE);
        drain();

        // longest header, magic length saturated, widest limit, cut in the payload
        set_config(8'd255, 4'd15, {$urandom, $urandom}, 8'd255);
        push_image(1'b1, skip_cfg, 1'b0, 32'd2, 32'd6, 255 + 8 * 19 + 3);
        drain();

        // restart after the cut; header skip changed while an image sits in its header
        set_config(8'd20, 4'd1, {$urandom, $urandom}, 8'd2);
        push_image(1'b1, skip_cfg, 1'b0, 32'd1, 32'd2, 10);
        drain();
        write_reg(REG_HEADER_SKIP, 64'd4);
        push_image(1'b0, 0, 1'b0, 32'd0, 32'd1, FULL_IMAGE);
        drain();

        // random phases, each with its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_config(8'(($urandom_range(0, 5) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12)),
                       4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                      : $urandom_range(0, 3)),
                       {$urandom, $urandom},
                       8'(($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 8)));
            if (p >= RANDOM_PHASES - 2)
            begin
                src_rate  = 0;
                sink_rate = 0;
            end
            else
            begin
                src_rate  = $urandom_range(5, 60);
                sink_rate = $urandom_range(5, 60);
            end
            target = items_queued + PHASE_ITEMS;
            while (items_queued < target)
                push_random_image();
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
